[rtl/i2c_master_byte_engine_assert.svh]
// assertion macros for the i2c byte engine checker
// no dependencies; each macro expects clock and reset in scope
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// property checked outside reset
`define I2CM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/i2cm_pkg.sv]
// shared types and constants for the i2c master byte engine
// no dependencies
`default_nettype none

package i2cm_pkg;

   // bus phase of the byte engine
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_S_WAIT = 4'd1,
      PH_S_HOLD = 4'd2,
      PH_S_LOW  = 4'd3,
      PH_P_SET  = 4'd4,
      PH_P_WAIT = 4'd5,
      PH_P_HOLD = 4'd6,
      PH_P_END  = 4'd7,
      PH_B_SET  = 4'd8,
      PH_B_WAIT = 4'd9,
      PH_B_HIGH = 4'd10,
      PH_B_END  = 4'd11
   } phase_type;

   // command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // register indexes
   localparam logic [0:0] REG_PHASE_TICKS   = 1'd0;
   localparam logic [0:0] REG_STRETCH_LIMIT = 1'd1;

   // register reset values
   localparam logic [15:0] PHASE_TICKS_RST   = 16'd4;
   localparam logic [15:0] STRETCH_LIMIT_RST = 16'd5000;

   // bits in a byte, index of the ack bit
   localparam logic [3:0] ACK_BIT = 4'd8;

   // packed widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

endpackage

`default_nettype wire

[rtl/i2c_master_byte_engine.sv]
// i2c master byte engine: start, stop, byte write and byte read on open-drain lines
// depends on i2cm_pkg
`default_nettype none

//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tuser: cmd; tdata: byte, ack, scl, sda
//  rsp     | out | rsp_tvalid/tready  | tdata: line drives, status, read byte
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// one tick item in, one result item out; an item is taken every cycle while rsp is not stalled
// the whole tick update sits between the state registers and the result register
// a result waiting on rsp stalls req only while rsp_tready is low
// synchronous reset returns to idle with both lines released and registers at defaults
// csr writes are always taken; csr_ready is tied high

module i2c_master_byte_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] write_byte, [8] ack_to_send, [9] scl_in, [10] sda_in, [15:11] zero
   input  wire logic [i2cm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] cmd
   input  wire logic [2:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] scl_pull_low, [1] sda_pull_low, [2] ready_res, [3] done_res,
   // [4] ack_seen, [12:5] read_data, [13] timeout, [15:14] zero
   output logic [i2cm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [0:0]                        csr_index,
   input  wire logic [15:0]                       csr_data
);
   import i2cm_pkg::*;

   // configuration
   logic [15:0] phase_ticks_ff;
   logic [15:0] stretch_limit_ff;

   // engine state
   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] phase_cnt_ff, phase_cnt_in;
   logic [15:0] stretch_cnt_ff, stretch_cnt_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_low_ff, scl_low_in;
   logic        sda_low_ff, sda_low_in;
   logic        is_read_ff, is_read_in;
   logic        ack_got_ff, ack_got_in;
   logic [7:0]  read_hold_ff, read_hold_in;

   // result register
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic       req_take;
   logic [2:0] cmd;
   logic [7:0] wr_byte;
   logic       ack_to_send, scl_in, sda_in;

   assign cmd         = req_tuser;
   assign wr_byte     = req_tdata[7:0];
   assign ack_to_send = req_tdata[8];
   assign scl_in      = req_tdata[9];
   assign sda_in      = req_tdata[10];

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff   <= PHASE_TICKS_RST;
         stretch_limit_ff <= STRETCH_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PHASE_TICKS:   phase_ticks_ff   <= csr_data;
            REG_STRETCH_LIMIT: stretch_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // one tick of the engine
   always_comb begin
      logic [15:0] pt_lim, sl_lim, pc_inc, sc_inc;
      logic        t_done, w_high, w_tmo, done, tmo, ack_out, drive;

      pt_lim = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
      sl_lim = (stretch_limit_ff == 16'd0) ? 16'd1 : stretch_limit_ff;
      pc_inc = phase_cnt_ff + 16'd1;
      sc_inc = stretch_cnt_ff + 16'd1;
      t_done = pc_inc >= pt_lim;
      w_high = scl_in;
      w_tmo  = !scl_in && (sc_inc >= sl_lim);
      done    = 1'b0;
      tmo     = 1'b0;
      ack_out = 1'b0;

      // data bit driven during the low phase of SCL
      if (bit_idx_ff < ACK_BIT) begin
         drive = is_read_ff ? 1'b0 : !shift_ff[7];
      end else begin
         drive = is_read_ff ? ack_choice_ff : 1'b0;
      end

      phase_in       = phase_ff;
      bit_idx_in     = bit_idx_ff;
      shift_in       = shift_ff;
      phase_cnt_in   = phase_cnt_ff;
      stretch_cnt_in = stretch_cnt_ff;
      ack_choice_in  = ack_choice_ff;
      scl_low_in     = scl_low_ff;
      sda_low_in     = sda_low_ff;
      is_read_in     = is_read_ff;
      ack_got_in     = ack_got_ff;
      read_hold_in   = read_hold_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd == CMD_START) begin
               scl_low_in = 1'b0;
               sda_low_in = 1'b0;
               phase_in   = PH_S_WAIT;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end else if (cmd == CMD_STOP) begin
               sda_low_in = 1'b1;
               phase_in   = PH_P_SET;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
               is_read_in    = (cmd == CMD_READ);
               shift_in      = (cmd == CMD_READ) ? 8'd0 : wr_byte;
               ack_choice_in = ack_to_send;
               ack_got_in    = 1'b0;
               bit_idx_in    = '0;
               scl_low_in    = 1'b1;
               phase_in      = PH_B_SET;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_S_WAIT: begin
            stretch_cnt_in = scl_in ? stretch_cnt_ff : sc_inc;
            if (w_high) begin
               phase_in = PH_S_HOLD;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_S_HOLD: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               sda_low_in = 1'b1;
               phase_in   = PH_S_LOW;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_S_LOW: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               scl_low_in = 1'b1;
               done       = 1'b1;
               phase_in   = PH_IDLE;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_P_SET: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               scl_low_in = 1'b0;
               phase_in   = PH_P_WAIT;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_P_WAIT: begin
            stretch_cnt_in = scl_in ? stretch_cnt_ff : sc_inc;
            if (w_high) begin
               phase_in = PH_P_HOLD;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_P_HOLD: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               sda_low_in = 1'b0;
               phase_in   = PH_P_END;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_P_END: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_B_SET: begin
            sda_low_in   = drive;
            phase_cnt_in = pc_inc;
            if (t_done) begin
               scl_low_in = 1'b0;
               phase_in   = PH_B_WAIT;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_B_WAIT: begin
            stretch_cnt_in = scl_in ? stretch_cnt_ff : sc_inc;
            if (w_high) begin
               // sample data bits on a read, the ack bit on a write
               if (is_read_ff && bit_idx_ff < ACK_BIT) begin
                  shift_in = {shift_ff[6:0], sda_in};
               end
               if (!is_read_ff && bit_idx_ff >= ACK_BIT) begin
                  ack_got_in = !sda_in;
               end
               phase_in = PH_B_HIGH;
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_B_HIGH: begin
            phase_cnt_in = pc_inc;
            if (t_done) begin
               scl_low_in = 1'b1;
               if (bit_idx_ff >= ACK_BIT) begin
                  phase_in = PH_B_END;
               end else begin
                  if (!is_read_ff) shift_in = {shift_ff[6:0], 1'b0};
                  bit_idx_in = bit_idx_ff + 4'd1;
                  phase_in   = PH_B_SET;
               end
               phase_cnt_in = '0; stretch_cnt_in = '0;
            end
         end
         PH_B_END: begin
            sda_low_in = 1'b0;
            if (is_read_ff) read_hold_in = shift_ff;
            else ack_out = ack_got_ff;
            done     = 1'b1;
            phase_in = PH_IDLE;
            phase_cnt_in = '0; stretch_cnt_in = '0;
         end
         default: begin
            phase_in = PH_IDLE;
            phase_cnt_in = '0; stretch_cnt_in = '0;
         end
      endcase

      // stretch timeout in any wait phase: release the bus and finish
      if ((phase_ff == PH_S_WAIT || phase_ff == PH_P_WAIT || phase_ff == PH_B_WAIT)
          && w_tmo) begin
         scl_low_in = 1'b0;
         sda_low_in = 1'b0;
         if (phase_ff == PH_B_WAIT && is_read_ff) read_hold_in = 8'd0;
         done     = 1'b1;
         tmo      = 1'b1;
         ack_out  = 1'b0;
         phase_in = PH_IDLE;
         phase_cnt_in = '0; stretch_cnt_in = '0;
      end

      rsp_tdata_in = {2'b00, tmo, read_hold_in, ack_out, done,
                      (phase_in == PH_IDLE), sda_low_in, scl_low_in};
   end

   // state registers, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_idx_ff     <= '0;
         shift_ff       <= '0;
         phase_cnt_ff   <= '0;
         stretch_cnt_ff <= '0;
         ack_choice_ff  <= 1'b0;
         scl_low_ff     <= 1'b0;
         sda_low_ff     <= 1'b0;
         is_read_ff     <= 1'b0;
         ack_got_ff     <= 1'b0;
         read_hold_ff   <= '0;
      end else if (req_take) begin
         phase_ff       <= phase_in;
         bit_idx_ff     <= bit_idx_in;
         shift_ff       <= shift_in;
         phase_cnt_ff   <= phase_cnt_in;
         stretch_cnt_ff <= stretch_cnt_in;
         ack_choice_ff  <= ack_choice_in;
         scl_low_ff     <= scl_low_in;
         sda_low_ff     <= sda_low_in;
         is_read_ff     <= is_read_in;
         ack_got_ff     <= ack_got_in;
         read_hold_ff   <= read_hold_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_tvalid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

endmodule

`default_nettype wire

[rtl/i2cm_checker.sv]
// port-level checker for the i2c master byte engine, bound to i2c_master_byte_engine
// depends on i2cm_pkg and i2c_master_byte_engine_assert.svh
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2cm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import i2cm_pkg::*;

   // result fields and handshake conditions
   logic rsp_scl_low, rsp_sda_low, rsp_ready, rsp_done, rsp_ack, rsp_tmo;
   logic rsp_stall, tmo_clean;

   assign rsp_scl_low = rsp_tdata[0];
   assign rsp_sda_low = rsp_tdata[1];
   assign rsp_ready   = rsp_tdata[2];
   assign rsp_done    = rsp_tdata[3];
   assign rsp_ack     = rsp_tdata[4];
   assign rsp_tmo     = rsp_tdata[13];
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign tmo_clean   = rsp_done && rsp_ready && !rsp_scl_low && !rsp_sda_low && !rsp_ack;

   // nothing pending on the result side right after reset
   `I2CM_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_tvalid, "result valid after reset")

   // a stalled result item holds its payload
   `I2CM_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // an empty result register never blocks input
   `I2CM_ASSERT(a_req_open, !rsp_tvalid |-> req_tready, "input stalled with empty output")

   // a timeout ends the command idle with both lines released and no ack
   `I2CM_ASSERT(a_tmo_release, rsp_tvalid && rsp_tmo |-> tmo_clean, "timeout without release")

   // ack is reported only on the completing tick
   `I2CM_ASSERT(a_ack_done, rsp_tvalid && rsp_ack |-> rsp_done && rsp_ready, "ack outside done")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
